// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`endif

// ----- rtl/scdp_pkg.sv -----
// shared types and constants for the sync code detector
`default_nettype none
package scdp_pkg;
  localparam int PENDING_DEPTH_DEF = 32;
  localparam int WORD_BITS_DEF = 16;
  localparam logic [31:0] SYNC_SAV = 32'hFF000080;
  localparam logic [31:0] SYNC_SAVI = 32'hFF0000AB;
  localparam logic [31:0] SYNC_EAV = 32'hFF00009D;
  localparam logic [31:0] SYNC_EAVI = 32'hFF0000B6;
  localparam logic [15:0] MIN_DEF = 16'd2500;
  localparam logic [15:0] MAX_DEF = 16'd3500;
  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_MIN = 2'd1;
  localparam logic [1:0] REG_MAX = 2'd2;
  localparam logic [1:0] KIND_SAV = 2'd0;
  localparam logic [1:0] KIND_SAVI = 2'd1;
  localparam logic [1:0] KIND_EAV = 2'd2;
  localparam logic [1:0] KIND_EAVI = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SHIFT, ST_READ, ST_CHECK, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic rd;
    logic expire;
    logic pair;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_bit;
    logic word_done;
    logic hit;
    logic is_end;
    logic empty;
    logic too_far;
  } stat_t;
endpackage
`default_nettype wire

// ----- rtl/sync_code_detect_and_pair.sv -----
// sync word detector with start/end pairing, top level
// operation: an accepted word is shifted bit by bit through the window match, then the result
// is presented from ST_OUT; an end code pauses the shift and passes through ST_READ and ST_CHECK
// once per queue entry examined: once per expired start plus once for the final check
// a new word is taken only when the result is accepted, never while a word is in progress
// reset: rst synchronous, clears window, bit count, queue counts and config registers to defaults
`default_nettype none
`include "assert_macros.svh"
module sync_code_detect_and_pair
  import scdp_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [((WORD_BITS+7)/8)*8-1:0] s_axis_tdata, // data_word
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // sync_found, sync_position, pair_found, pair_class,
  // pair_start_position, queue_overflow, zero pad
  output logic [71:0]               m_axis_tdata,
  output logic [1:0]                m_axis_tuser, // sync_kind
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);
  cmd_t cmd;
  stat_t st;
  logic [69:0] result;

  scdp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .st(st), .cmd(cmd)
  );

  scdp_dp #(.PENDING_DEPTH(PENDING_DEPTH), .WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .data_word(s_axis_tdata[WORD_BITS-1:0]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .result(result)
  );

  assign m_axis_tdata = {4'b0, result[69:3], result[0]};
  assign m_axis_tuser = result[2:1];

  `ASSERT_IMP(a_no_accept_busy, cmd.shift, !s_axis_tready)
  `ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.shift, cmd.rd, cmd.expire, cmd.pair}))
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
`default_nettype wire

// ----- rtl/scdp_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none
module scdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/scdp_ctrl.sv -----
// controller state machine
`default_nettype none
module scdp_ctrl
  import scdp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t st,
  output cmd_t       cmd
);
  state_t state, state_next;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (st.hit && st.is_end) begin
          state_next = ST_READ;
        end else if (st.last_bit) begin
          state_next = ST_OUT;
          cmd.out_load = 1'b1;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (st.empty) begin
          state_next = st.word_done ? ST_OUT : ST_SHIFT;
          cmd.out_load = st.word_done;
        end else if (st.too_far) begin
          cmd.expire = 1'b1;
          state_next = ST_READ;
        end else begin
          cmd.pair = 1'b1;
          state_next = st.word_done ? ST_OUT : ST_SHIFT;
          cmd.out_load = st.word_done;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.load = 1'b1;
            state_next = ST_SHIFT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/scdp_dp.sv -----
// datapath: bit unpacking, window match, start queues and result
`default_nettype none
module scdp_dp
  import scdp_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output stat_t                     st,
  input  wire logic [WORD_BITS-1:0] data_word,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  output logic [69:0]               result
);
  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);
  localparam logic [CW:0] DEPTH_W = (CW+1)'(PENDING_DEPTH);
  localparam logic [AW-1:0] HEAD_LAST = AW'(PENDING_DEPTH - 1);
  localparam logic [BW-1:0] LAST_C = BW'(WORD_BITS - 1);

  logic order_lsb;
  logic [15:0] min_d, max_d;
  logic [WORD_BITS-1:0] word;
  logic [BW-1:0] bidx;
  logic [30:0] bit_window;
  logic [31:0] bit_counter;
  logic [31:0] win;
  logic [31:0] end_pos;
  logic cls;
  logic [AW-1:0] head [2];
  logic [CW-1:0] cnt [2];
  logic [31:0] rdata [2];
  logic found, pfound, pclass, over;
  logic [1:0] kind;
  logic [31:0] spos, ppos;
  logic bit_in, hit;
  logic [1:0] k;
  logic [31:0] gap;
  logic fits;
  logic [CW:0] tsum [2];
  logic [AW-1:0] tail [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      order_lsb <= 1'b1;
      min_d <= MIN_DEF;
      max_d <= MAX_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORDER: order_lsb <= cfg_data[0];
        REG_MIN: min_d <= cfg_data;
        REG_MAX: max_d <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    bit_in = order_lsb ? word[bidx] : word[LAST_C - bidx];
    win = {bit_window, bit_in};
    hit = 1'b1;
    k = KIND_SAV;
    priority case (win)
      SYNC_SAV: k = KIND_SAV;
      SYNC_SAVI: k = KIND_SAVI;
      SYNC_EAV: k = KIND_EAV;
      SYNC_EAVI: k = KIND_EAVI;
      default: hit = 1'b0;
    endcase
    gap = end_pos - rdata[cls];
    fits = !(gap < {16'd0, min_d});
    for (int q = 0; q < 2; q++) begin
      tsum[q] = {1'b0, CW'(head[q])} + {1'b0, cnt[q]};
      tail[q] = (tsum[q] >= DEPTH_W) ? AW'(tsum[q] - DEPTH_W) : AW'(tsum[q]);
    end
    st.last_bit = (bidx == LAST_C);
    st.word_done = (bidx == '0);
    st.hit = hit;
    st.is_end = k[1];
    st.empty = (cnt[cls] == '0);
    st.too_far = (gap > {16'd0, max_d});
  end

  for (genvar q = 0; q < 2; q++) begin : g_q
    logic we;
    assign we = cmd.shift && hit && !k[1] && (k[0] == 1'(q));
    scdp_ram #(.WIDTH(32), .DEPTH(PENDING_DEPTH)) u_ram (
      .clk(clk), .we(we), .waddr(tail[q]), .wdata(bit_counter - 32'd31),
      .raddr(head[q]), .rdata(rdata[q])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        head[q] <= '0;
        cnt[q] <= '0;
      end else if (we) begin
        if (cnt[q] == DEPTH_C) begin
          head[q] <= (head[q] == HEAD_LAST) ? '0 : head[q] + AW'(1);
        end else begin
          cnt[q] <= cnt[q] + CW'(1);
        end
      end else if ((cmd.expire || (cmd.pair && fits)) && cls == 1'(q)) begin
        head[q] <= (head[q] == HEAD_LAST) ? '0 : head[q] + AW'(1);
        cnt[q] <= cnt[q] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_window <= '0;
      bit_counter <= '0;
      bidx <= '0;
    end else if (cmd.shift) begin
      bit_window <= win[30:0];
      bit_counter <= bit_counter + 32'd1;
      bidx <= st.last_bit ? '0 : bidx + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= data_word;
      found <= 1'b0;
      kind <= '0;
      spos <= '0;
      pfound <= 1'b0;
      pclass <= 1'b0;
      ppos <= '0;
      over <= 1'b0;
    end
    if (cmd.shift && hit) begin
      found <= 1'b1;
      kind <= k;
      spos <= bit_counter - 32'd31;
      pfound <= 1'b0;
      pclass <= 1'b0;
      ppos <= '0;
      cls <= k[0];
      end_pos <= bit_counter - 32'd31;
      if (!k[1] && cnt[k[0]] == DEPTH_C) begin
        over <= 1'b1;
      end
    end
    if (cmd.pair && fits) begin
      pfound <= 1'b1;
      pclass <= cls;
      ppos <= rdata[cls];
    end
  end

  assign result = {over, ppos, pclass, pfound, spos, kind, found};
endmodule
`default_nettype wire
